@@ hw/rtl/dbct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbct_pkg
// Shared types, codes and helpers of the debounced bell button and chime
// timer unit.
// ----------------------------------------------------------------------------
package dbct_pkg;

  // Counter and register widths.
  localparam int unsigned CntW      = 16;
  localparam int unsigned DebounceW = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Register reset values.
  localparam logic [DebounceW-1:0] DebounceRst = DebounceW'(50);
  localparam logic [CntW-1:0]      RingRst     = CntW'(1500);
  localparam logic [CntW-1:0]      LockRst     = CntW'(3000);

  // Remote command codes.
  localparam logic [1:0] FUNC_NONE    = 2'd0;
  localparam logic [1:0] FUNC_ENABLE  = 2'd1;
  localparam logic [1:0] FUNC_DISABLE = 2'd2;
  localparam logic [1:0] FUNC_RING    = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RING     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOCK     = 2'd2;

  // One tick beat on the input side.
  typedef struct packed {
    logic [1:0] func;
    logic       button_level;
    logic       publish_accepted;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic chime_drive;
    logic publish_request;
    logic ring_ended;
    logic channel_enabled;
    logic press_active;
  } out_t;

  // Increment that sticks at the all-ones value.
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    if (&v) begin
      r = v;
    end else begin
      r = v + CntW'(1);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/debounced_bell_button_and_chime_timer_unit.sv @@
`timescale 1ns / 1ps
// Each result beat is registered as its tick beat is accepted. Throughput:
// one tick beat per cycle while not stalled; the whole update is a single
// pass of short logic from the state registers into the result register.
// Reset: counters clear, the last level reads released, the channel is
// enabled and the registers take their default values (50, 1500, 3000).
// ----------------------------------------------------------------------------
// debounced_bell_button_and_chime_timer_unit
// Startup lockout, button debounce, press/publish tracking and a one-shot
// chime timer for one bell channel, stepped once per tick beat.
// ----------------------------------------------------------------------------
module debounced_bell_button_and_chime_timer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  dbct_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dbct_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [dbct_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dbct_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  // Configuration registers.
  logic [dbct_pkg::DebounceW-1:0] debounce_q;
  logic [dbct_pkg::CntW-1:0]      ring_ticks_q;
  logic [dbct_pkg::CntW-1:0]      lock_ticks_q;

  // Channel state.
  logic [dbct_pkg::CntW-1:0] lock_q, lock_d;
  logic [dbct_pkg::CntW-1:0] settle_q, settle_d;
  logic [dbct_pkg::CntW-1:0] ring_el_q, ring_el_d;
  logic last_q, last_d;
  logic pressed_q, pressed_d;
  logic published_q, published_d;
  logic ringing_q, ringing_d;
  logic enable_q, enable_d;

  // Result register.
  logic           out_valid_q;
  dbct_pkg::out_t out_q, out_d;

  logic in_accept;
  logic trigger;
  logic started;
  logic ended;
  logic ring_active;

  // A new beat is taken unless a finished result is stuck in the output.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= dbct_pkg::DebounceRst;
      ring_ticks_q <= dbct_pkg::RingRst;
      lock_ticks_q <= dbct_pkg::LockRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dbct_pkg::CFG_DEBOUNCE: debounce_q   <= cfg_wdata_i[dbct_pkg::DebounceW-1:0];
        dbct_pkg::CFG_RING:     ring_ticks_q <= cfg_wdata_i;
        dbct_pkg::CFG_LOCK:     lock_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state and result of one tick.
  always_comb begin
    lock_d      = dbct_pkg::sat_inc(lock_q);
    settle_d    = settle_q;
    ring_el_d   = ring_el_q;
    last_d      = in_data_i.button_level;
    pressed_d   = pressed_q;
    published_d = published_q;
    ringing_d   = ringing_q;
    enable_d    = enable_q;
    trigger     = 1'b0;
    started     = 1'b0;
    ended       = 1'b0;
    ring_active = 1'b0;

    // The command acts before the button processing.
    case (in_data_i.func)
      dbct_pkg::FUNC_ENABLE:  enable_d = 1'b1;
      dbct_pkg::FUNC_DISABLE: enable_d = 1'b0;
      dbct_pkg::FUNC_RING:    trigger  = 1'b1;
      default: ;
    endcase

    if (lock_q < lock_ticks_q) begin
      // Lockout: track the level only, ring state stays frozen.
      settle_d    = '0;
      pressed_d   = 1'b0;
      published_d = 1'b0;
    end else begin
      // Debounce: the level must hold longer than the settle time.
      if (in_data_i.button_level != last_q) begin
        settle_d = '0;
      end else begin
        settle_d = dbct_pkg::sat_inc(settle_q);
      end

      if (settle_d > {{(dbct_pkg::CntW-dbct_pkg::DebounceW){1'b0}}, debounce_q}) begin
        if (!in_data_i.button_level) begin
          if (!pressed_q) begin
            pressed_d   = 1'b1;
            published_d = 1'b0;
            trigger     = 1'b1;
          end
        end else begin
          pressed_d = 1'b0;
        end
      end

      // One-shot chime timer.
      started     = trigger & enable_d & ~ringing_q;
      ring_active = ringing_q | started;
      if (started) begin
        ring_el_d = '0;
      end else if (ringing_q) begin
        ring_el_d = dbct_pkg::sat_inc(ring_el_q);
      end
      ringing_d = ring_active;
      if (ring_active && (ring_el_d >= ring_ticks_q)) begin
        ringing_d = 1'b0;
        ended     = 1'b1;
      end

      // Publish handshake with the network side.
      if (pressed_d && !published_d && in_data_i.publish_accepted) begin
        published_d = 1'b1;
      end
    end

    out_d.chime_drive     = ringing_d;
    out_d.publish_request = pressed_d & ~published_d;
    out_d.ring_ended      = ended;
    out_d.channel_enabled = enable_d;
    out_d.press_active    = pressed_d;
  end

  // State registers, updated on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q      <= '0;
      settle_q    <= '0;
      ring_el_q   <= '0;
      last_q      <= 1'b1;
      pressed_q   <= 1'b0;
      published_q <= 1'b0;
      ringing_q   <= 1'b0;
      enable_q    <= 1'b1;
    end else if (in_accept) begin
      lock_q      <= lock_d;
      settle_q    <= settle_d;
      ring_el_q   <= ring_el_d;
      last_q      <= last_d;
      pressed_q   <= pressed_d;
      published_q <= published_d;
      ringing_q   <= ringing_d;
      enable_q    <= enable_d;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  // A ring that ends in a tick leaves the chime off.
  a_end_chime_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.ring_ended |-> !out_q.chime_drive)
    else $error("ring_ended reported with chime still driven");

  // A publish request only exists while the press flag is set.
  a_req_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.publish_request |-> out_q.press_active)
    else $error("publish request without a press");

  // The lockout counter never runs backwards.
  a_lock_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 lock_q >= $past(lock_q))
    else $error("lockout counter decreased");

  // A fresh ring starts its timer from zero.
  a_ring_starts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ringing_q) |-> ring_el_q == '0)
    else $error("ring timer not cleared at ring start");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bell button and chime timer unit. A queue of
// tick beats feeds a driver with random gaps, and a monitor with random
// stalls checks every result beat against an in-bench model of the lockout,
// debounce, publish and chime timer behavior. Registers are rewritten between
// phases while the unit is idle, including the extreme settings.
// ----------------------------------------------------------------------------
module testbench;

  // Index past the end of the register list; a write there must do nothing.
  localparam logic [dbct_pkg::CfgIdxW-1:0] REG_UNUSED = 2'd3;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          tick_valid = 1'b0;
  logic                          tick_stall;
  dbct_pkg::in_t                 tick_beat  = '0;
  logic                          res_valid;
  logic                          res_stall  = 1'b0;
  dbct_pkg::out_t                res_beat;
  logic                          cfg_we     = 1'b0;
  logic [dbct_pkg::CfgIdxW-1:0]  cfg_idx    = '0;
  logic [dbct_pkg::CfgDataW-1:0] cfg_wdata  = '0;

  // Model copy of the registers.
  logic [dbct_pkg::DebounceW-1:0] db_limit = dbct_pkg::DebounceRst;
  logic [dbct_pkg::CntW-1:0]      ring_len = dbct_pkg::RingRst;
  logic [dbct_pkg::CntW-1:0]      lock_len = dbct_pkg::LockRst;

  // Model copy of the channel state.
  logic [dbct_pkg::CntW-1:0] lock_cnt   = '0;
  logic                      level_q    = 1'b1;
  logic [dbct_pkg::CntW-1:0] settle_cnt = '0;
  logic                      press_q    = 1'b0;
  logic                      sent_q     = 1'b0;
  logic                      ring_on    = 1'b0;
  logic [dbct_pkg::CntW-1:0] ring_cnt   = '0;
  logic                      chan_en    = 1'b1;

  dbct_pkg::in_t  pending_ticks[$];
  dbct_pkg::out_t due_results[$];
  dbct_pkg::out_t want_beat;
  int   mismatches = 0;
  int   send_gap   = 0;
  int   stall_left = 0;
  int   calm_left[2];

  debounced_bell_button_and_chime_timer_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (tick_valid),
    .in_stall_o  (tick_stall),
    .in_data_i   (tick_beat),
    .out_valid_o (res_valid),
    .out_stall_i (res_stall),
    .out_data_o  (res_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [dbct_pkg::CntW-1:0] bump16(
    input logic [dbct_pkg::CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Idle length for one side: mostly none or short, a few long, and now
  // and then a calm stretch with no idling at all.
  function automatic int pick_idle(input int side);
    int r;
    r = $urandom_range(0, 99);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 10);
    end else if (r < 98) begin
      return $urandom_range(12, 30);
    end
    calm_left[side] = $urandom_range(20, 60);
    return 0;
  endfunction

  // Advances the channel model by one tick and returns the result beat.
  function automatic dbct_pkg::out_t predict_tick(input dbct_pkg::in_t t);
    dbct_pkg::out_t r;
    logic fire;
    logic started;
    logic ended;
    fire    = 1'b0;
    started = 1'b0;
    ended   = 1'b0;

    // The command acts before the button is looked at.
    case (t.func)
      dbct_pkg::FUNC_ENABLE:  chan_en = 1'b1;
      dbct_pkg::FUNC_DISABLE: chan_en = 1'b0;
      dbct_pkg::FUNC_RING:    fire = 1'b1;
      default: ;
    endcase

    if (lock_cnt < lock_len) begin
      // Startup lockout: track the level only, ring state stays frozen.
      level_q    = t.button_level;
      settle_cnt = '0;
      press_q    = 1'b0;
      sent_q     = 1'b0;
      lock_cnt   = bump16(lock_cnt);
    end else begin
      lock_cnt = bump16(lock_cnt);

      // Debounce: a level change restarts the settle count.
      if (t.button_level != level_q) begin
        settle_cnt = '0;
      end else begin
        settle_cnt = bump16(settle_cnt);
      end
      level_q = t.button_level;

      if (settle_cnt > dbct_pkg::CntW'(db_limit)) begin
        if (!t.button_level) begin
          if (!press_q) begin
            press_q = 1'b1;
            sent_q  = 1'b0;
            fire    = 1'b1;
          end
        end else begin
          press_q = 1'b0;
        end
      end

      // One-shot chime; requests while busy or disabled are lost.
      if (fire && chan_en && !ring_on) begin
        ring_on  = 1'b1;
        ring_cnt = '0;
        started  = 1'b1;
      end
      if (ring_on) begin
        if (!started) begin
          ring_cnt = bump16(ring_cnt);
        end
        if (ring_cnt >= ring_len) begin
          ring_on = 1'b0;
          ended   = 1'b1;
        end
      end

      if (press_q && !sent_q && t.publish_accepted) begin
        sent_q = 1'b1;
      end
    end

    r.chime_drive     = ring_on;
    r.publish_request = press_q && !sent_q;
    r.ring_ended      = ended;
    r.channel_enabled = chan_en;
    r.press_active    = press_q;
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) begin
      log_mismatch($sformatf("%s got %b, expected %b", name, got, want));
    end
  endtask

  // Driver: presents queued tick beats, with random gaps between them.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      tick_valid <= 1'b0;
      tick_beat  <= '0;
      send_gap   = 0;
    end else if (!tick_valid || !tick_stall) begin
      if (send_gap > 0) begin
        send_gap--;
        tick_valid <= 1'b0;
      end else if (pending_ticks.size() > 0) begin
        tick_beat  <= pending_ticks.pop_front();
        tick_valid <= 1'b1;
        send_gap   = pick_idle(0);
      end else begin
        tick_valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every accepted tick, checks every accepted result
  // and stalls the result side at random.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_stall  <= 1'b0;
      stall_left = 0;
      lock_cnt   = '0;
      level_q    = 1'b1;
      settle_cnt = '0;
      press_q    = 1'b0;
      sent_q     = 1'b0;
      ring_on    = 1'b0;
      ring_cnt   = '0;
      chan_en    = 1'b1;
    end else begin
      if (tick_valid && !tick_stall) begin
        due_results.push_back(predict_tick(tick_beat));
      end
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          log_mismatch("result beat with nothing expected");
        end else begin
          want_beat = due_results.pop_front();
          check_field("chime_drive", res_beat.chime_drive, want_beat.chime_drive);
          check_field("publish_request", res_beat.publish_request,
                      want_beat.publish_request);
          check_field("ring_ended", res_beat.ring_ended, want_beat.ring_ended);
          check_field("channel_enabled", res_beat.channel_enabled,
                      want_beat.channel_enabled);
          check_field("press_active", res_beat.press_active, want_beat.press_active);
        end
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
        stall_left = pick_idle(1);
      end
    end
  end

  task automatic push_tick(input logic [1:0] func, input logic lvl, input logic acc);
    dbct_pkg::in_t t;
    t.func             = func;
    t.button_level     = lvl;
    t.publish_accepted = acc;
    pending_ticks.push_back(t);
  endtask

  // Waits until every tick is sent and every result is back, plus margin.
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || tick_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dbct_pkg::CfgIdxW-1:0] idx,
                           input logic [dbct_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dbct_pkg::CFG_DEBOUNCE: db_limit = val[dbct_pkg::DebounceW-1:0];
      dbct_pkg::CFG_RING:     ring_len = val;
      dbct_pkg::CFG_LOCK:     lock_len = val;
      default: ;
    endcase
  endtask

  function automatic logic [1:0] pick_func();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) begin
      return dbct_pkg::FUNC_NONE;
    end else if (r == 14) begin
      return dbct_pkg::FUNC_ENABLE;
    end else if (r == 15) begin
      return dbct_pkg::FUNC_DISABLE;
    end
    return dbct_pkg::FUNC_RING;
  endfunction

  // Alternating press and release runs with some short bounces mixed in;
  // below a debounce limit of 32 they are mostly long enough to debounce.
  task automatic gen_ticks(input int count, input int db);
    int   made;
    int   run;
    int   k;
    int   r;
    logic lvl;
    made = 0;
    lvl  = 1'b1;
    while (made < count) begin
      lvl = ~lvl;
      r   = $urandom_range(0, 9);
      if (r < 2) begin
        run = $urandom_range(1, 2);
      end else if (db < 32) begin
        run = $urandom_range(db + 1, db + 8);
      end else begin
        run = $urandom_range(1, 40);
      end
      for (k = 0; k < run && made < count; k++) begin
        push_tick(pick_func(), lvl, ($urandom_range(0, 3) == 0));
        made++;
      end
    end
  endtask

  initial begin
    int ph;
    int db;
    int rl;
    int lk;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Power-up lockout: ring requests and the button are ignored, enable
    // and disable still act.
    push_tick(dbct_pkg::FUNC_RING, 1'b0, 1'b1);
    push_tick(dbct_pkg::FUNC_DISABLE, 1'b0, 1'b1);
    push_tick(dbct_pkg::FUNC_ENABLE, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b0, 1'b0);
    wait_idle();

    // Short settings; the lockout is raised so two more ticks stay locked.
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(dbct_pkg::CFG_DEBOUNCE, 16'hFC02);
    write_reg(dbct_pkg::CFG_RING, 16'd3);
    write_reg(dbct_pkg::CFG_LOCK, 16'd6);

    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    // Press: publish accept before the press counts is ignored.
    push_tick(dbct_pkg::FUNC_NONE, 1'b0, 1'b1);
    push_tick(dbct_pkg::FUNC_NONE, 1'b0, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b0, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b0, 1'b0);
    // Ring command while already ringing, then the event is published.
    push_tick(dbct_pkg::FUNC_RING, 1'b0, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b0, 1'b1);
    // Release with a bounce; the ring finishes on the way.
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b0, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    // Ring while disabled is lost; after enable it starts.
    push_tick(dbct_pkg::FUNC_DISABLE, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_RING, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_ENABLE, 1'b1, 1'b1);
    push_tick(dbct_pkg::FUNC_RING, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b0);
    wait_idle();

    // Zero ring time: the ring starts and ends in one tick.
    write_reg(dbct_pkg::CFG_RING, 16'd0);
    push_tick(dbct_pkg::FUNC_RING, 1'b1, 1'b0);
    push_tick(dbct_pkg::FUNC_NONE, 1'b1, 1'b1);
    wait_idle();

    // Random phases, each with its own register setting.
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          db = 0;
          rl = 0;
          lk = 0;
        end
        1: begin
          // Longest settings: a press never settles, a ring keeps going.
          db = 1023;
          rl = 65535;
          lk = 0;
        end
        2: begin
          // Lockout entered again while the long ring is frozen.
          db = 3;
          rl = 20;
          lk = 65535;
        end
        5: begin
          db = $urandom_range(0, 8);
          rl = $urandom_range(0, 12);
          lk = lock_cnt + $urandom_range(2, 6);
        end
        default: begin
          db = $urandom_range(0, 8);
          rl = $urandom_range(0, 12);
          lk = $urandom_range(0, 2);
        end
      endcase
      write_reg(dbct_pkg::CFG_DEBOUNCE, dbct_pkg::CfgDataW'(db));
      write_reg(dbct_pkg::CFG_RING, dbct_pkg::CfgDataW'(rl));
      write_reg(dbct_pkg::CFG_LOCK, dbct_pkg::CfgDataW'(lk));
      if (ph == 1) begin
        push_tick(dbct_pkg::FUNC_RING, 1'b1, 1'b0);
      end
      gen_ticks((ph == 2) ? 30 : 85, db);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
